// ===== rtl/spdc_pkg.sv =====
// Shared constants, types and per-tick pulse functions for the pulse duration classifier.
`timescale 1ns / 1ps
`default_nettype none

package spdc_pkg;

  localparam int WINDOW_HALF = 2;
  localparam int WIN_LEN     = 2 * WINDOW_HALF + 1;
  localparam int MAX_NEURONS = 1024;
  localparam int MAX_TICKS   = 65536;

  localparam int CNT_W   = 11;
  localparam int TICK_W  = 16;
  localparam int IDX_W   = $clog2(MAX_TICKS + 1);
  localparam int DUR_W   = 17;
  localparam int SUM_W   = $clog2(WIN_LEN * MAX_NEURONS + 1);
  localparam int THR_W   = 13;
  localparam int CMP_W   = (SUM_W > THR_W) ? SUM_W : THR_W;
  localparam int RATIO_W = 16;
  localparam int GAP_W   = 16;
  localparam int Q_FRAC  = 8;
  localparam int PROD_W  = RATIO_W + DUR_W;
  localparam int CLS_W   = 2;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = ((2 * CNT_W + 7) / 8) * 8;
  localparam int OUT_BITS   = CLS_W + 2 * DUR_W + 2 * TICK_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int OUT_D1_LSB = CLS_W;
  localparam int OUT_D2_LSB = OUT_D1_LSB + DUR_W;

  localparam logic [RATIO_W-1:0] RATIO_FLOOR_RST = RATIO_W'(128);
  localparam logic [RATIO_W-1:0] RATIO_CEIL_RST  = RATIO_W'(512);
  localparam logic [THR_W-1:0]   MIN_SPK_RST     = THR_W'(10);
  localparam logic [GAP_W-1:0]   MAX_GAP_RST     = GAP_W'(10);

  typedef logic [CNT_W-1:0] cnt_t;
  typedef cnt_t [WIN_LEN-1:0] win_t;

  typedef struct packed {
    logic              seen;
    logic              over;
    logic [TICK_W-1:0] start;
    logic [TICK_W-1:0] last_sync;
  } pulse_t;

  typedef enum logic [CLS_W-1:0] {
    CLS_STABLE      = 2'd0,
    CLS_EPILEPSY    = 2'd1,
    CLS_NO_ACTIVITY = 2'd2
  } class_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_RATIO_FLOOR       = 2'd0,
    CFG_RATIO_CEIL        = 2'd1,
    CFG_MIN_WINDOW_SPIKES = 2'd2,
    CFG_MAX_GAP           = 2'd3
  } cfg_idx_t;

  // Control shared by both layer lanes.
  typedef struct packed {
    logic                   tick_take;
    logic                   run_end;
    logic [IDX_W-1:0]       tick_index;
    logic [TICK_W-1:0]      last_idx;
    logic [WINDOW_HALF-1:0] flush_load;
    logic [THR_W-1:0]       min_spikes;
    logic [GAP_W-1:0]       max_gap;
  } lane_ctl_t;

  // Load enables of the result stages.
  typedef struct packed {
    logic m_load;
    logic o_load;
  } merge_ctl_t;

  function automatic win_t win_shift(win_t w, cnt_t v);
    win_t q;
    for (int k = 0; k < WIN_LEN - 1; k++) begin
      q[k] = w[k+1];
    end
    q[WIN_LEN-1] = v;
    return q;
  endfunction

  function automatic logic [SUM_W-1:0] win_sum(win_t w);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int k = 0; k < WIN_LEN; k++) begin
      s = s + SUM_W'(w[k]);
    end
    return s;
  endfunction

  // Update one layer's pulse tracking with the window centered on tick tau.
  function automatic pulse_t judge(pulse_t p, logic [SUM_W-1:0] sum, logic [TICK_W-1:0] tau,
                                   logic [THR_W-1:0] thr, logic [GAP_W-1:0] gap);
    pulse_t            q;
    logic [TICK_W-1:0] since;
    q     = p;
    since = tau - p.last_sync;
    if (!p.over) begin
      if (CMP_W'(sum) >= CMP_W'(thr)) begin
        if (!p.seen) begin
          q.start = tau;
          q.seen  = 1'b1;
        end
        q.last_sync = tau;
      end else if (p.seen && (GAP_W'(since) > gap)) begin
        q.over = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/spdc_lane.sv =====
// One layer lane: count window, pulse tracking and trailing-window flush stages.
`timescale 1ns / 1ps
`default_nettype none

module spdc_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  spdc_pkg::lane_ctl_t         ctl,
  input  logic [spdc_pkg::CNT_W-1:0]  count,
  output logic [spdc_pkg::DUR_W-1:0]  duration,
  output logic [spdc_pkg::TICK_W-1:0] start
);
  import spdc_pkg::*;

  win_t   win_r, win_nxt;
  pulse_t pulse_r, pulse_nxt;

  cnt_t   cnt_sat;
  logic   tick_live;
  win_t   win_step, win_end;
  pulse_t pulse_step, pulse_end;

  win_t              fl_win_r   [WINDOW_HALF];
  pulse_t            fl_pulse_r [WINDOW_HALF];
  logic [TICK_W-1:0] fl_last_r  [WINDOW_HALF];

  pulse_t tail;

  assign cnt_sat   = (count > CNT_W'(MAX_NEURONS)) ? CNT_W'(MAX_NEURONS) : count;
  assign tick_live = ctl.tick_index < IDX_W'(MAX_TICKS);
  assign win_step  = win_shift(win_r, cnt_sat);

  // The newest count completes the window of the tick WINDOW_HALF back.
  assign pulse_step = (ctl.tick_index >= IDX_W'(WINDOW_HALF)) ?
      judge(pulse_r, win_sum(win_step), TICK_W'(ctl.tick_index - IDX_W'(WINDOW_HALF)),
            ctl.min_spikes, ctl.max_gap) : pulse_r;

  assign win_end   = tick_live ? win_step : win_r;
  assign pulse_end = tick_live ? pulse_step : pulse_r;

  always_comb begin
    win_nxt   = win_r;
    pulse_nxt = pulse_r;
    if (ctl.tick_take) begin
      if (ctl.run_end) begin
        win_nxt   = '0;
        pulse_nxt = '0;
      end else if (tick_live) begin
        win_nxt   = win_step;
        pulse_nxt = pulse_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      pulse_r <= '0;
    end else begin
      win_r   <= win_nxt;
      pulse_r <= pulse_nxt;
    end
  end

  // One stage per trailing tick: shift in a zero and judge the next window.
  for (genvar s = 0; s < WINDOW_HALF; s++) begin : g_flush
    win_t              src_win;
    pulse_t            src_pulse;
    logic [TICK_W-1:0] fl_last_nxt;
    logic [IDX_W-1:0]  newest;
    win_t              fl_win_nxt;
    pulse_t            fl_pulse_nxt;

    if (s == 0) begin : g_head
      assign src_win     = win_end;
      assign src_pulse   = pulse_end;
      assign fl_last_nxt = ctl.last_idx;
    end else begin : g_next
      assign src_win     = fl_win_r[s-1];
      assign src_pulse   = fl_pulse_r[s-1];
      assign fl_last_nxt = fl_last_r[s-1];
    end

    assign fl_win_nxt   = win_shift(src_win, '0);
    assign newest       = IDX_W'(fl_last_nxt) + IDX_W'(s + 1);
    assign fl_pulse_nxt = (newest >= IDX_W'(WINDOW_HALF)) ?
        judge(src_pulse, win_sum(fl_win_nxt), TICK_W'(newest - IDX_W'(WINDOW_HALF)),
              ctl.min_spikes, ctl.max_gap) : src_pulse;

    always_ff @(posedge clk) begin
      if (ctl.flush_load[s]) begin
        fl_win_r[s]   <= fl_win_nxt;
        fl_pulse_r[s] <= fl_pulse_nxt;
        fl_last_r[s]  <= fl_last_nxt;
      end
    end
  end

  assign tail     = fl_pulse_r[WINDOW_HALF-1];
  assign duration = tail.seen ?
      (DUR_W'(tail.last_sync) - DUR_W'(tail.start) + DUR_W'(1)) : '0;
  assign start    = tail.seen ? tail.start : '0;

endmodule

`default_nettype wire

// ===== rtl/spdc_merge.sv =====
// Merging stage: ratio products of both lanes, classification and result register.
`timescale 1ns / 1ps
`default_nettype none

module spdc_merge (
  input  logic                            clk,
  input  spdc_pkg::merge_ctl_t            ctl,
  input  logic [spdc_pkg::RATIO_W-1:0]    ratio_floor,
  input  logic [spdc_pkg::RATIO_W-1:0]    ratio_ceil,
  input  logic [spdc_pkg::DUR_W-1:0]      dur_first,
  input  logic [spdc_pkg::DUR_W-1:0]      dur_second,
  input  logic [spdc_pkg::TICK_W-1:0]     st_first,
  input  logic [spdc_pkg::TICK_W-1:0]     st_second,
  output logic [spdc_pkg::OUT_DATA_W-1:0] out_data
);
  import spdc_pkg::*;

  logic [DUR_W-1:0]      d1_r, d2_r;
  logic [TICK_W-1:0]     s1_r, s2_r;
  logic [PROD_W-1:0]     pmin_r, pmax_r;
  logic [PROD_W-1:0]     scaled;
  class_t                cls;
  logic [OUT_DATA_W-1:0] out_r, out_nxt;

  always_ff @(posedge clk) begin
    if (ctl.m_load) begin
      d1_r   <= dur_first;
      d2_r   <= dur_second;
      s1_r   <= st_first;
      s2_r   <= st_second;
      pmin_r <= PROD_W'(ratio_floor) * PROD_W'(dur_second);
      pmax_r <= PROD_W'(ratio_ceil) * PROD_W'(dur_second);
    end
  end

  // Compare 256*d1 against ratio*d2 instead of dividing.
  assign scaled = PROD_W'(d1_r) << Q_FRAC;

  always_comb begin
    if ((d1_r == '0) || (d2_r == '0)) begin
      cls = CLS_NO_ACTIVITY;
    end else if (scaled < pmin_r) begin
      cls = CLS_EPILEPSY;
    end else if (scaled > pmax_r) begin
      cls = CLS_NO_ACTIVITY;
    end else begin
      cls = CLS_STABLE;
    end
  end

  assign out_nxt = OUT_DATA_W'({s2_r, s1_r, d2_r, d1_r, cls});

  always_ff @(posedge clk) begin
    if (ctl.o_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== rtl/synfire_pulse_duration_classifier_core.sv =====
// Top level: config registers, tick counter, handshake pipeline, two lanes and merge.
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    in_tdata: count_first, count_second; in_tlast: last_tick
//   out_     out  out_tvalid/out_tready  out_tdata: class, durations, starts
//   cfg_     in   cfg_we                 cfg_addr (register index), cfg_wdata
//
// One tick request is taken every cycle while in_tready is high; the window add and compare of each lane sets that.
// A last tick walks through WINDOW_HALF flush stages, the multiply stage and the result
// register before its result is valid, while new ticks keep flowing.
// Synchronous reset clears the run state, the stage valids and loads default register values.
// A stalled result holds its stage; stages behind it fill before in_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module synfire_pulse_duration_classifier_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [spdc_pkg::IN_DATA_W-1:0]  in_tdata,   // count_first, count_second, zero fill
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [spdc_pkg::OUT_DATA_W-1:0] out_tdata,  // activity_class, duration_first,
                                                      // duration_second, start_first,
                                                      // start_second, zero fill
  input  logic                            cfg_we,
  input  logic [spdc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [spdc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import spdc_pkg::*;

  logic [RATIO_W-1:0] ratio_floor_r, ratio_floor_nxt;
  logic [RATIO_W-1:0] ratio_ceil_r, ratio_ceil_nxt;
  logic [THR_W-1:0]   min_spk_r, min_spk_nxt;
  logic [GAP_W-1:0]   max_gap_r, max_gap_nxt;

  logic [IDX_W-1:0]   tick_index_r, tick_index_nxt;

  logic [WINDOW_HALF-1:0] fv_r, fv_nxt;
  logic                   mv_r, mv_nxt;
  logic                   ov_r, ov_nxt;
  logic [WINDOW_HALF:0]   f_ready;
  logic [WINDOW_HALF-1:0] f_load;
  logic                   m_ready, o_ready;
  logic                   in_acc;

  lane_ctl_t  lane_ctl;
  merge_ctl_t merge_ctl;

  logic [DUR_W-1:0]  dur_first, dur_second;
  logic [TICK_W-1:0] st_first, st_second;

  logic [CLS_W-1:0] out_cls;
  logic [DUR_W-1:0] out_d1, out_d2;

  // Configuration writes
  always_comb begin
    ratio_floor_nxt = ratio_floor_r;
    ratio_ceil_nxt  = ratio_ceil_r;
    min_spk_nxt     = min_spk_r;
    max_gap_nxt     = max_gap_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_RATIO_FLOOR:       ratio_floor_nxt = RATIO_W'(cfg_wdata);
        CFG_RATIO_CEIL:        ratio_ceil_nxt  = RATIO_W'(cfg_wdata);
        CFG_MIN_WINDOW_SPIKES: min_spk_nxt     = cfg_wdata[THR_W-1:0];
        CFG_MAX_GAP:           max_gap_nxt     = GAP_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Ready chain from the result register back to the input
  always_comb begin
    o_ready = !ov_r || out_tready;
    m_ready = !mv_r || o_ready;
    f_ready[WINDOW_HALF] = m_ready;
    for (int s = WINDOW_HALF - 1; s >= 0; s--) begin
      f_ready[s] = !fv_r[s] || f_ready[s+1];
    end
    in_acc    = in_tvalid && f_ready[0];
    f_load[0] = in_acc && in_tlast;
    for (int s = 1; s < WINDOW_HALF; s++) begin
      f_load[s] = fv_r[s-1] && f_ready[s];
    end
    for (int s = 0; s < WINDOW_HALF; s++) begin
      fv_nxt[s] = f_load[s] || (fv_r[s] && !f_ready[s+1]);
    end
    merge_ctl.m_load = fv_r[WINDOW_HALF-1] && m_ready;
    mv_nxt           = merge_ctl.m_load || (mv_r && !o_ready);
    merge_ctl.o_load = mv_r && o_ready;
    ov_nxt           = merge_ctl.o_load || (ov_r && !out_tready);
  end

  // Tick counter: stop at the cap, restart after the last tick
  always_comb begin
    tick_index_nxt = tick_index_r;
    if (in_acc) begin
      if (in_tlast) begin
        tick_index_nxt = '0;
      end else if (tick_index_r < IDX_W'(MAX_TICKS)) begin
        tick_index_nxt = tick_index_r + IDX_W'(1);
      end
    end
  end

  always_comb begin
    lane_ctl.tick_take  = in_acc;
    lane_ctl.run_end    = in_acc && in_tlast;
    lane_ctl.tick_index = tick_index_r;
    lane_ctl.last_idx   = (tick_index_r < IDX_W'(MAX_TICKS)) ?
                          tick_index_r[TICK_W-1:0] : '1;
    lane_ctl.flush_load = f_load;
    lane_ctl.min_spikes = min_spk_r;
    lane_ctl.max_gap    = max_gap_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_floor_r <= RATIO_FLOOR_RST;
      ratio_ceil_r  <= RATIO_CEIL_RST;
      min_spk_r     <= MIN_SPK_RST;
      max_gap_r     <= MAX_GAP_RST;
      tick_index_r  <= '0;
      fv_r          <= '0;
      mv_r          <= 1'b0;
      ov_r          <= 1'b0;
    end else begin
      ratio_floor_r <= ratio_floor_nxt;
      ratio_ceil_r  <= ratio_ceil_nxt;
      min_spk_r     <= min_spk_nxt;
      max_gap_r     <= max_gap_nxt;
      tick_index_r  <= tick_index_nxt;
      fv_r          <= fv_nxt;
      mv_r          <= mv_nxt;
      ov_r          <= ov_nxt;
    end
  end

  spdc_lane u_lane_first (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (lane_ctl),
    .count    (in_tdata[CNT_W-1:0]),
    .duration (dur_first),
    .start    (st_first)
  );

  spdc_lane u_lane_second (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (lane_ctl),
    .count    (in_tdata[2*CNT_W-1:CNT_W]),
    .duration (dur_second),
    .start    (st_second)
  );

  spdc_merge u_merge (
    .clk         (clk),
    .ctl         (merge_ctl),
    .ratio_floor (ratio_floor_r),
    .ratio_ceil  (ratio_ceil_r),
    .dur_first   (dur_first),
    .dur_second  (dur_second),
    .st_first    (st_first),
    .st_second   (st_second),
    .out_data    (out_tdata)
  );

  assign in_tready  = f_ready[0];
  assign out_tvalid = ov_r;

  assign out_cls = out_tdata[CLS_W-1:0];
  assign out_d1  = out_tdata[OUT_D1_LSB +: DUR_W];
  assign out_d2  = out_tdata[OUT_D2_LSB +: DUR_W];

  a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tick_index_r <= IDX_W'(MAX_TICKS))
    else $error("tick counter ran past its cap");

  a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> (tick_index_r == '0))
    else $error("tick counter not cleared after last tick");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(mv_r))
    else $error("result appeared without a multiply stage entry");

  a_idle_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ((out_d1 == '0) || (out_d2 == '0))) |-> (out_cls == CLS_NO_ACTIVITY))
    else $error("missing pulse not classed as no activity");

endmodule

`default_nettype wire

// ===== tb/synfire_pulse_duration_classifier_core_test.sv =====
// Self-checking bench for the pulse duration classifier: directed ticks and random runs.
`timescale 1ns / 1ps

module synfire_pulse_duration_classifier_core_test;
  import spdc_pkg::*;

  // Result fields, MSB first so the struct lines up with out_tdata from bit 0.
  typedef struct packed {
    logic [TICK_W-1:0] s2;
    logic [TICK_W-1:0] s1;
    logic [DUR_W-1:0]  d2;
    logic [DUR_W-1:0]  d1;
    class_t            cls;
  } verdict_t;

  typedef struct {
    int unsigned c1;
    int unsigned c2;
    bit          last;
    bit          typed;
    verdict_t    want;
  } probe_t;

  typedef struct {
    int unsigned lo;
    int unsigned hi;
    int unsigned level;
    int unsigned gap;
  } regset_t;

  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int NUM_PHASES      = 10;

  localparam verdict_t V_NONE = '0;
  localparam verdict_t V_EMPTY = '{s2: '0, s1: '0, d2: '0, d1: '0, cls: CLS_NO_ACTIVITY};
  localparam verdict_t V_SINGLE = '{s2: '0, s1: '0, d2: 17'd1, d1: 17'd1, cls: CLS_STABLE};
  localparam verdict_t V_FIRST_ONLY = '{s2: '0, s1: '0, d2: '0, d1: 17'd1,
                                        cls: CLS_NO_ACTIVITY};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // count_first, count_second, zero fill
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // activity_class, duration_first, duration_second,
                                      // start_first, start_second, zero fill
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predictor state and register copies.
  int unsigned lo_ratio, hi_ratio, sync_level, gap_limit;
  int unsigned recent [2][WIN_LEN];
  int unsigned ticks_taken;
  bit          pulse_on [2];
  bit          pulse_done [2];
  int unsigned pulse_begin [2];
  int unsigned pulse_last [2];

  verdict_t pending_verdicts[$];
  int       mismatches;
  int       quiet_cycles;
  int       rx_stall;
  bit       tx_idle, rx_idle;

  regset_t plan [7] = '{
    '{128, 512, 10, 10},
    '{0, 0, 0, 0},
    '{65535, 65535, 8191, 65535},
    '{1, 65535, 1, 0},
    '{256, 256, 20, 3},
    '{65535, 1, 15, 1},
    '{200, 400, 30, 5}
  };

  probe_t probes [23] = '{
    '{0, 0, 1'b1, 1'b1, V_EMPTY},
    '{2047, 2047, 1'b1, 1'b1, V_SINGLE},
    '{1025, 0, 1'b1, 1'b1, V_FIRST_ONLY},
    '{1024, 1, 1'b0, 1'b0, V_NONE},
    '{0, 2, 1'b0, 1'b0, V_NONE},
    '{0, 4, 1'b0, 1'b0, V_NONE},
    '{0, 8, 1'b0, 1'b0, V_NONE},
    '{0, 16, 1'b0, 1'b0, V_NONE},
    '{0, 32, 1'b0, 1'b0, V_NONE},
    '{0, 64, 1'b0, 1'b0, V_NONE},
    '{0, 128, 1'b0, 1'b0, V_NONE},
    '{0, 256, 1'b0, 1'b0, V_NONE},
    '{0, 512, 1'b0, 1'b0, V_NONE},
    '{0, 1024, 1'b0, 1'b0, V_NONE},
    '{1365, 682, 1'b0, 1'b0, V_NONE},
    '{682, 1365, 1'b1, 1'b0, V_NONE},
    '{10, 1024, 1'b0, 1'b0, V_NONE},
    '{0, 1024, 1'b0, 1'b0, V_NONE},
    '{0, 1024, 1'b0, 1'b0, V_NONE},
    '{0, 1024, 1'b0, 1'b0, V_NONE},
    '{0, 1024, 1'b0, 1'b0, V_NONE},
    '{0, 1024, 1'b0, 1'b0, V_NONE},
    '{0, 1024, 1'b1, 1'b0, V_NONE}
  };

  synfire_pulse_duration_classifier_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_run();
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < WIN_LEN; k++) begin
        recent[l][k] = 0;
      end
      pulse_on[l]    = 1'b0;
      pulse_done[l]  = 1'b0;
      pulse_begin[l] = 0;
      pulse_last[l]  = 0;
    end
    ticks_taken = 0;
  endfunction

  function automatic void shift_in(int l, int unsigned v);
    for (int k = 0; k < WIN_LEN - 1; k++) begin
      recent[l][k] = recent[l][k+1];
    end
    recent[l][WIN_LEN-1] = v;
  endfunction

  // Judge the tick centered in the window, WINDOW_HALF behind the newest one.
  function automatic void judge_center(int unsigned newest);
    int unsigned tau, total;
    if (newest < WINDOW_HALF) return;
    tau = newest - WINDOW_HALF;
    for (int l = 0; l < 2; l++) begin
      total = 0;
      for (int k = 0; k < WIN_LEN; k++) begin
        total += recent[l][k];
      end
      if (!pulse_done[l]) begin
        if (total >= sync_level) begin
          if (!pulse_on[l]) begin
            pulse_begin[l] = tau;
            pulse_on[l]    = 1'b1;
          end
          pulse_last[l] = tau;
        end else if (pulse_on[l] && (tau - pulse_last[l] > gap_limit)) begin
          pulse_done[l] = 1'b1;
        end
      end
    end
  endfunction

  function automatic bit step_classifier(input int unsigned c1, input int unsigned c2,
                                         input bit last, output verdict_t v);
    int unsigned       a, b, lastidx;
    longint unsigned   dur [2];
    int unsigned       st [2];
    a = (c1 > MAX_NEURONS) ? MAX_NEURONS : c1;
    b = (c2 > MAX_NEURONS) ? MAX_NEURONS : c2;
    v = '0;
    if (ticks_taken < MAX_TICKS) begin
      shift_in(0, a);
      shift_in(1, b);
      judge_center(ticks_taken);
      ticks_taken++;
    end
    if (!last) return 1'b0;
    lastidx = ticks_taken - 1;
    for (int k = 1; k <= WINDOW_HALF; k++) begin
      shift_in(0, 0);
      shift_in(1, 0);
      judge_center(lastidx + k);
    end
    for (int l = 0; l < 2; l++) begin
      dur[l] = pulse_on[l] ? longint'(pulse_last[l] - pulse_begin[l]) + 1 : 0;
      st[l]  = pulse_on[l] ? pulse_begin[l] : 0;
    end
    if (dur[0] == 0 || dur[1] == 0) v.cls = CLS_NO_ACTIVITY;
    else if ((dur[0] << 8) < longint'(lo_ratio) * dur[1]) v.cls = CLS_EPILEPSY;
    else if ((dur[0] << 8) > longint'(hi_ratio) * dur[1]) v.cls = CLS_NO_ACTIVITY;
    else v.cls = CLS_STABLE;
    v.d1 = dur[0][DUR_W-1:0];
    v.d2 = dur[1][DUR_W-1:0];
    v.s1 = st[0][TICK_W-1:0];
    v.s2 = st[1][TICK_W-1:0];
    clear_run();
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (!tx_idle || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Mostly quiet outside a burst, mostly moderate inside; rare wide noise anywhere.
  function automatic int unsigned pick_count(bit active);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return $urandom_range(0, 2047);
    if (active) return (r < 3) ? $urandom_range(0, 1024) : $urandom_range(2, 14);
    return (r < 3) ? $urandom_range(0, 6) : 0;
  endfunction

  task automatic send_tick(input int unsigned c1, input int unsigned c2, input bit last,
                           input bit typed, input verdict_t typed_want);
    verdict_t made;
    int       gap;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({c2[CNT_W-1:0], c1[CNT_W-1:0]});
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (step_classifier(c1[CNT_W-1:0], c2[CNT_W-1:0], last, made)) begin
      pending_verdicts.push_back(typed ? typed_want : made);
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tlast  <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain every pending result, then let the pipeline empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs(input regset_t s);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_RATIO_FLOOR;
    cfg_wdata <= s.lo[15:0];
    @(posedge clk);
    lo_ratio  = s.lo & 16'hFFFF;
    cfg_addr  <= CFG_RATIO_CEIL;
    cfg_wdata <= s.hi[15:0];
    @(posedge clk);
    hi_ratio  = s.hi & 16'hFFFF;
    cfg_addr  <= CFG_MIN_WINDOW_SPIKES;
    cfg_wdata <= {3'($urandom_range(0, 7)), s.level[THR_W-1:0]};
    @(posedge clk);
    sync_level = s.level & 13'h1FFF;
    cfg_addr  <= CFG_MAX_GAP;
    cfg_wdata <= s.gap[15:0];
    @(posedge clk);
    gap_limit = s.gap & 16'hFFFF;
    cfg_we    <= 1'b0;
  endtask

  task automatic random_run(output int sent);
    int          n;
    int          b0 [2], b1 [2], r0 [2], r1 [2];
    int unsigned cnt [2];
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
    for (int l = 0; l < 2; l++) begin
      b0[l] = $urandom_range(0, n - 1);
      b1[l] = b0[l] + $urandom_range(0, n);
      r0[l] = b1[l] + $urandom_range(1, 25);
      r1[l] = r0[l] + $urandom_range(0, 8);
    end
    for (int i = 0; i < n; i++) begin
      for (int l = 0; l < 2; l++) begin
        cnt[l] = pick_count((i >= b0[l] && i <= b1[l]) || (i >= r0[l] && i <= r1[l]));
      end
      send_tick(cnt[0], cnt[1], i == n - 1, 1'b0, V_NONE);
    end
    sent = n;
  endtask

  task automatic check_field(input string what, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    verdict_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[OUT_BITS-1:0];
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("activity_class", want.cls, got.cls);
        check_field("duration_first", want.d1, got.d1);
        check_field("duration_second", want.d2, got.d2);
        check_field("start_first", want.s1, got.s1);
        check_field("start_second", want.s2, got.s2);
      end
    end
  end

  always @(posedge clk) begin
    if (!rx_idle) begin
      out_tready <= 1'b1;
    end else if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall--;
    end else begin
      out_tready <= 1'b1;
      case ($urandom_range(0, 15))
        0, 1, 2: rx_stall = $urandom_range(1, 3);
        3:       rx_stall = $urandom_range(10, 40);
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    regset_t s;
    int      sent, phase_items;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_RATIO_FLOOR;
    cfg_wdata  = '0;
    rst_n      = 1'b0;
    tx_idle    = 1'b1;
    rx_idle    = 1'b1;
    rx_stall   = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    lo_ratio   = RATIO_FLOOR_RST;
    hi_ratio   = RATIO_CEIL_RST;
    sync_level = MIN_SPK_RST;
    gap_limit  = MAX_GAP_RST;
    clear_run();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probes[i]) begin
      send_tick(probes[i].c1, probes[i].c2, probes[i].last, probes[i].typed, probes[i].want);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      if (phase < 7) begin
        s = plan[phase];
      end else begin
        s.lo    = $urandom_range(1, 1024);
        s.hi    = s.lo + $urandom_range(0, 1024);
        s.level = $urandom_range(0, 60);
        s.gap   = $urandom_range(0, 20);
      end
      program_regs(s);
      tx_idle = (phase % 3 != 1);
      rx_idle = (phase % 4 != 2);
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        random_run(sent);
        phase_items += sent;
      end
    end

    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
